FILE: src/h2r_pkg.sv
// Shared types, constants and hue functions for the HSV to RGB pixel converter.
`timescale 1ns / 1ps

package h2r_pkg;

    // Hue handling: full circle and width of one sector, in degrees.
    localparam int HUE_W      = 9;
    localparam int HUE_FULL   = 360;
    localparam int SECTOR_DEG = 60;
    localparam int REM_W      = 6;

    // Channel scale and the width of the scaled value before the divide by 60.
    localparam int CHAN_W = 8;
    localparam int Y_W    = 14;

    // Reciprocal divide by 60: exact for every scaled value below 2**14.
    localparam int DIV60_MUL   = 17477;
    localparam int DIV60_SHIFT = 20;
    localparam int DIV60_PW    = 29;

    // Sector of the color wheel, hue div 60.
    typedef logic [2:0] sector_t;

    localparam sector_t SECTOR_0 = 3'd0;
    localparam sector_t SECTOR_1 = 3'd1;
    localparam sector_t SECTOR_2 = 3'd2;
    localparam sector_t SECTOR_3 = 3'd3;
    localparam sector_t SECTOR_4 = 3'd4;
    localparam sector_t SECTOR_5 = 3'd5;

    // Lanes of the channel datapath: v, p, q and t.
    localparam int LANES = 4;
    localparam int CH_V  = 0;
    localparam int CH_P  = 1;
    localparam int CH_Q  = 2;
    localparam int CH_T  = 3;

    // Sector of a hue that is already folded into 0..359.
    function automatic sector_t sector_of(input logic [HUE_W-1:0] hue);
        sector_t sec;
        if (hue >= HUE_W'(5 * SECTOR_DEG))
            sec = SECTOR_5;
        else if (hue >= HUE_W'(4 * SECTOR_DEG))
            sec = SECTOR_4;
        else if (hue >= HUE_W'(3 * SECTOR_DEG))
            sec = SECTOR_3;
        else if (hue >= HUE_W'(2 * SECTOR_DEG))
            sec = SECTOR_2;
        else if (hue >= HUE_W'(SECTOR_DEG))
            sec = SECTOR_1;
        else
            sec = SECTOR_0;
        return sec;
    endfunction

    // First hue of a sector, in degrees.
    function automatic logic [HUE_W-1:0] sector_base(input sector_t sec);
        logic [HUE_W-1:0] base;
        case (sec)
            SECTOR_0: base = HUE_W'(0);
            SECTOR_1: base = HUE_W'(SECTOR_DEG);
            SECTOR_2: base = HUE_W'(2 * SECTOR_DEG);
            SECTOR_3: base = HUE_W'(3 * SECTOR_DEG);
            SECTOR_4: base = HUE_W'(4 * SECTOR_DEG);
            default:  base = HUE_W'(5 * SECTOR_DEG);
        endcase
        return base;
    endfunction

endpackage

FILE: src/hsv_to_rgb_converter.sv
// Pipelined HSV to 8-bit RGB pixel converter.
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// hsv       hsv_valid / hsv_stall   hue[8:0], saturation[12:0], brightness[12:0]
// rgb       rgb_valid / rgb_stall   red[7:0], green[7:0], blue[7:0]
//
// One pixel enters per clock while a valid rgb result is not stalled.
// The five register stages hold: sector split, the numerators 60*ONE - s*k, the v*m
// products, the scale by 255, and the reciprocal divide by 60 with routing.
// Reset clears only the stage valid bits; the data registers need no reset.
// A stall on a valid rgb result freezes every stage at once and is passed back as hsv_stall.
module hsv_to_rgb_converter #(
    parameter int FRAC_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        hsv_valid,
    output logic        hsv_stall,
    input  logic [8:0]  hue,
    input  logic [12:0] saturation,
    input  logic [12:0] brightness,
    output logic        rgb_valid,
    input  logic        rgb_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    // Datapath widths: fraction value, numerator, v*m product, product times 255.
    localparam int          WV     = FRAC_BITS + 1;
    localparam int          WM     = FRAC_BITS + 7;
    localparam int          WP     = 2 * FRAC_BITS + 6;
    localparam int          WX     = 2 * FRAC_BITS + 14;
    localparam logic [31:0] ONE32  = 32'd1 << FRAC_BITS;
    localparam logic [WM-1:0] FULL_M = WM'(h2r_pkg::SECTOR_DEG) << FRAC_BITS;

    // Pipeline advance: everything moves unless a held result is stalled.
    logic advance;

    assign advance   = !(rgb_valid && rgb_stall);
    assign hsv_stall = !advance;

    // Stage valid bits.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= hsv_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign rgb_valid = v5_reg;

    // Stage 1: fold the hue, split it into sector and remainder, clamp s and v.
    logic [h2r_pkg::HUE_W-1:0] hue_fold;
    h2r_pkg::sector_t          sec1_next;
    logic [h2r_pkg::HUE_W-1:0] rem_full;
    logic [31:0]               s_clamp, v_clamp;

    h2r_pkg::sector_t          sec1_reg;
    logic [h2r_pkg::REM_W-1:0] rem1_reg;
    logic [WV-1:0]             s1_reg, v1d_reg;

    always_comb
    begin
        hue_fold  = (hue >= h2r_pkg::HUE_W'(h2r_pkg::HUE_FULL)) ? '0 : hue;
        sec1_next = h2r_pkg::sector_of(hue_fold);
        rem_full  = hue_fold - h2r_pkg::sector_base(sec1_next);
        s_clamp   = (32'(saturation) > ONE32) ? ONE32 : 32'(saturation);
        v_clamp   = (32'(brightness) > ONE32) ? ONE32 : 32'(brightness);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sec1_reg <= sec1_next;
            rem1_reg <= rem_full[h2r_pkg::REM_W-1:0];
            s1_reg   <= s_clamp[WV-1:0];
            v1d_reg  <= v_clamp[WV-1:0];
        end
    end

    // Stage 2: numerators m = 60*ONE - s*k, with k = 0, 60, r and 60-r per lane.
    logic [h2r_pkg::REM_W-1:0] k2 [h2r_pkg::LANES];
    logic [WM-1:0]             m2_next [h2r_pkg::LANES];
    logic [WM-1:0]             m2_reg [h2r_pkg::LANES];
    h2r_pkg::sector_t          sec2_reg;
    logic [WV-1:0]             v2d_reg;

    always_comb
    begin
        k2[h2r_pkg::CH_V] = '0;
        k2[h2r_pkg::CH_P] = h2r_pkg::REM_W'(h2r_pkg::SECTOR_DEG);
        k2[h2r_pkg::CH_Q] = rem1_reg;
        k2[h2r_pkg::CH_T] = h2r_pkg::REM_W'(h2r_pkg::SECTOR_DEG) - rem1_reg;
        for (int i = 0; i < h2r_pkg::LANES; i++)
        begin
            m2_next[i] = FULL_M - (WM'(s1_reg) * WM'(k2[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m2_reg   <= m2_next;
            sec2_reg <= sec1_reg;
            v2d_reg  <= v1d_reg;
        end
    end

    // Stage 3: multiply each numerator by the value.
    logic [WP-1:0]    p3_reg [h2r_pkg::LANES];
    h2r_pkg::sector_t sec3_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < h2r_pkg::LANES; i++)
            begin
                p3_reg[i] <= WP'(v2d_reg) * WP'(m2_reg[i]);
            end
            sec3_reg <= sec2_reg;
        end
    end

    // Stage 4: scale by 255 as a shift and subtract, then drop the 2F fraction bits.
    logic [WX-1:0]             x4 [h2r_pkg::LANES];
    logic [h2r_pkg::Y_W-1:0]   y4_reg [h2r_pkg::LANES];
    h2r_pkg::sector_t          sec4_reg;

    always_comb
    begin
        for (int i = 0; i < h2r_pkg::LANES; i++)
        begin
            x4[i] = (WX'(p3_reg[i]) << 8) - WX'(p3_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < h2r_pkg::LANES; i++)
            begin
                y4_reg[i] <= x4[i][2 * FRAC_BITS + h2r_pkg::Y_W - 1 : 2 * FRAC_BITS];
            end
            sec4_reg <= sec3_reg;
        end
    end

    // Stage 5: divide by 60 through the reciprocal, then route lanes by sector.
    logic [h2r_pkg::DIV60_PW-1:0] d5 [h2r_pkg::LANES];
    logic [h2r_pkg::CHAN_W-1:0]   c5 [h2r_pkg::LANES];
    logic [7:0]                   red_next, green_next, blue_next;
    logic [7:0]                   red_reg, green_reg, blue_reg;

    always_comb
    begin
        for (int i = 0; i < h2r_pkg::LANES; i++)
        begin
            d5[i] = h2r_pkg::DIV60_PW'(y4_reg[i]) *
                    h2r_pkg::DIV60_PW'(h2r_pkg::DIV60_MUL);
            c5[i] = d5[i][h2r_pkg::DIV60_SHIFT + h2r_pkg::CHAN_W - 1 : h2r_pkg::DIV60_SHIFT];
        end
        case (sec4_reg)
            h2r_pkg::SECTOR_0:
            begin
                red_next   = c5[h2r_pkg::CH_V];
                green_next = c5[h2r_pkg::CH_T];
                blue_next  = c5[h2r_pkg::CH_P];
            end
            h2r_pkg::SECTOR_1:
            begin
                red_next   = c5[h2r_pkg::CH_Q];
                green_next = c5[h2r_pkg::CH_V];
                blue_next  = c5[h2r_pkg::CH_P];
            end
            h2r_pkg::SECTOR_2:
            begin
                red_next   = c5[h2r_pkg::CH_P];
                green_next = c5[h2r_pkg::CH_V];
                blue_next  = c5[h2r_pkg::CH_T];
            end
            h2r_pkg::SECTOR_3:
            begin
                red_next   = c5[h2r_pkg::CH_P];
                green_next = c5[h2r_pkg::CH_Q];
                blue_next  = c5[h2r_pkg::CH_V];
            end
            h2r_pkg::SECTOR_4:
            begin
                red_next   = c5[h2r_pkg::CH_T];
                green_next = c5[h2r_pkg::CH_P];
                blue_next  = c5[h2r_pkg::CH_V];
            end
            default:
            begin
                red_next   = c5[h2r_pkg::CH_V];
                green_next = c5[h2r_pkg::CH_P];
                blue_next  = c5[h2r_pkg::CH_Q];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the HSV to RGB pixel converter.
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC_BITS   = 12;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int PHASE_ITEMS = 500;
    localparam int DRAIN_WAIT  = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_N       = 24;

    // One RGB pixel as the block returns it.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // One request; known marks rows whose result is typed in by hand.
    typedef struct packed {
        logic [8:0]  hue;
        logic [12:0] sat;
        logic [12:0] bri;
        logic        known;
        rgb_t        rgb;
    } hsv_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        hsv_valid = 1'b0;
    logic        hsv_stall;
    logic [8:0]  hue = '0;
    logic [12:0] saturation = '0;
    logic [12:0] brightness = '0;
    logic        rgb_valid;
    logic        rgb_stall = 1'b0;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    // Hand-written expectation that travels with the current request.
    logic        row_known = 1'b0;
    rgb_t        row_rgb = '0;

    int          send_idle = 0;
    int          recv_idle = 0;
    int          err_count = 0;
    int          cycle_count = 0;
    rgb_t        rgb_expected [$];

    // Directed rows: hue, saturation, brightness, known, red, green, blue.
    hsv_row_t directed_rows [DIR_N] = '{
        {9'd0,   13'd0,    13'd0,    1'b1, 8'd0,   8'd0,   8'd0},
        {9'd0,   13'd0,    13'd4096, 1'b1, 8'd255, 8'd255, 8'd255},
        {9'd0,   13'd0,    13'd2048, 1'b1, 8'd127, 8'd127, 8'd127},
        {9'd0,   13'd4096, 13'd4096, 1'b1, 8'd255, 8'd0,   8'd0},
        {9'd60,  13'd4096, 13'd4096, 1'b1, 8'd255, 8'd255, 8'd0},
        {9'd120, 13'd4096, 13'd4096, 1'b1, 8'd0,   8'd255, 8'd0},
        {9'd180, 13'd4096, 13'd4096, 1'b1, 8'd0,   8'd255, 8'd255},
        {9'd240, 13'd4096, 13'd4096, 1'b1, 8'd0,   8'd0,   8'd255},
        {9'd300, 13'd4096, 13'd4096, 1'b1, 8'd255, 8'd0,   8'd255},
        {9'd360, 13'd4096, 13'd4096, 1'b1, 8'd255, 8'd0,   8'd0},
        {9'd511, 13'd4096, 13'd4096, 1'b1, 8'd255, 8'd0,   8'd0},
        {9'd361, 13'd4096, 13'd4096, 1'b1, 8'd255, 8'd0,   8'd0},
        {9'd0,   13'd8191, 13'd8191, 1'b1, 8'd255, 8'd0,   8'd0},
        {9'd200, 13'd8191, 13'd0,    1'b1, 8'd0,   8'd0,   8'd0},
        {9'd100, 13'd0,    13'd8191, 1'b1, 8'd255, 8'd255, 8'd255},
        {9'd359, 13'd4096, 13'd4096, 1'b0, 24'd0},
        {9'd59,  13'd4096, 13'd4096, 1'b0, 24'd0},
        {9'd30,  13'd2048, 13'd3000, 1'b0, 24'd0},
        {9'd90,  13'd1000, 13'd4096, 1'b0, 24'd0},
        {9'd150, 13'd4095, 13'd4095, 1'b0, 24'd0},
        {9'd210, 13'd1,    13'd1,    1'b0, 24'd0},
        {9'd270, 13'd3333, 13'd2222, 1'b0, 24'd0},
        {9'd330, 13'd4097, 13'd4097, 1'b0, 24'd0},
        {9'd256, 13'd5000, 13'd6000, 1'b0, 24'd0}
    };

    hsv_to_rgb_converter #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .hsv_valid(hsv_valid),
        .hsv_stall(hsv_stall),
        .hue(hue),
        .saturation(saturation),
        .brightness(brightness),
        .rgb_valid(rgb_valid),
        .rgb_stall(rgb_stall),
        .red(red),
        .green(green),
        .blue(blue)
    );

    always #5 clk = ~clk;

    // Scale one channel: floor(255 * v * num / (60 * ONE * ONE)).
    function automatic logic [7:0] scale_255(input longint unsigned v,
                                             input longint unsigned num);
        longint unsigned den;
        den = longint'(h2r_pkg::SECTOR_DEG) * ONE * ONE;
        return 8'((64'd255 * v * num) / den);
    endfunction

    // Expected pixel for one HSV request.
    function automatic rgb_t hsv_pixel_rgb(input logic [8:0] h_in,
                                           input logic [12:0] s_in,
                                           input logic [12:0] v_in);
        longint unsigned  s, v, h, rem, full;
        logic [7:0]       cv, cp, cq, ct;
        h2r_pkg::sector_t sec;
        rgb_t             px;
        s    = (s_in > ONE) ? ONE : s_in;
        v    = (v_in > ONE) ? ONE : v_in;
        // Hues of 360 and above fold to zero.
        h    = (h_in >= h2r_pkg::HUE_FULL) ? 0 : h_in;
        sec  = h2r_pkg::sector_t'(h / h2r_pkg::SECTOR_DEG);
        rem  = h % h2r_pkg::SECTOR_DEG;
        full = longint'(h2r_pkg::SECTOR_DEG) * ONE;
        cv   = scale_255(v, full);
        cp   = scale_255(v, longint'(h2r_pkg::SECTOR_DEG) * (ONE - s));
        cq   = scale_255(v, full - s * rem);
        ct   = scale_255(v, full - s * (h2r_pkg::SECTOR_DEG - rem));
        case (sec)
            h2r_pkg::SECTOR_0: px = '{cv, ct, cp};
            h2r_pkg::SECTOR_1: px = '{cq, cv, cp};
            h2r_pkg::SECTOR_2: px = '{cp, cv, ct};
            h2r_pkg::SECTOR_3: px = '{cp, cq, cv};
            h2r_pkg::SECTOR_4: px = '{ct, cp, cv};
            default:           px = '{cv, cp, cq};
        endcase
        return px;
    endfunction

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge clk)
    begin
        rgb_stall <= ($urandom_range(99) < recv_idle);
    end

    // Record each accepted request, then check each accepted pixel.
    always @(posedge clk)
    begin : scoreboard
        rgb_t want;
        rgb_t got;
        if (rst_n)
        begin
            if (hsv_valid && !hsv_stall)
            begin
                if (row_known)
                    rgb_expected.push_back(row_rgb);
                else
                    rgb_expected.push_back(hsv_pixel_rgb(hue, saturation, brightness));
            end
            if (rgb_valid && !rgb_stall)
            begin
                got = '{red, green, blue};
                if (rgb_expected.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected pixel, expected none, got %0d/%0d/%0d",
                             $time, got.red, got.green, got.blue);
                end
                else
                begin
                    want = rgb_expected.pop_front();
                    if (got !== want)
                    begin
                        err_count++;
                        $display("%0t: pixel mismatch, expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 $time, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one request after random idle cycles; returns on the falling edge after acceptance.
    task automatic send_request(input hsv_row_t row);
        while ($urandom_range(99) < send_idle)
        begin
            hsv_valid <= 1'b0;
            @(negedge clk);
        end
        hsv_valid  <= 1'b1;
        hue        <= row.hue;
        saturation <= row.sat;
        brightness <= row.bri;
        row_known  <= row.known;
        row_rgb    <= row.rgb;
        do
            @(posedge clk);
        while (hsv_stall);
        @(negedge clk);
    endtask

    // Hold the sender off until every expected pixel has come back.
    task automatic drain_pixels();
        hsv_valid <= 1'b0;
        while (rgb_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        hsv_row_t row;
        int       pick;
        // Hold reset, then release it on a falling edge.
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table with no idling.
        for (int i = 0; i < DIR_N; i++)
            send_request(directed_rows[i]);
        drain_pixels();

        // Three random phases with different idling on each side.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 36;
                    recv_idle = 88;
                end
                1:
                begin
                    send_idle = 88;
                    recv_idle = 36;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                row.known = 1'b0;
                row.rgb   = '0;
                // Mostly legal hues, with wrap and over-range values mixed in.
                pick = $urandom_range(99);
                if (pick < 80)
                    row.hue = 9'($urandom_range(h2r_pkg::HUE_FULL - 1));
                else if (pick < 85)
                    row.hue = 9'(h2r_pkg::HUE_FULL);
                else
                    row.hue = 9'($urandom_range(511));
                // Saturation and value: legal range, extremes, or any 13-bit code.
                pick = $urandom_range(99);
                if (pick < 70)
                    row.sat = 13'($urandom_range(ONE));
                else if (pick < 80)
                    row.sat = ($urandom_range(1) != 0) ? 13'(ONE) : 13'd0;
                else
                    row.sat = 13'($urandom_range(8191));
                pick = $urandom_range(99);
                if (pick < 70)
                    row.bri = 13'($urandom_range(ONE));
                else if (pick < 80)
                    row.bri = ($urandom_range(1) != 0) ? 13'(ONE) : 13'd0;
                else
                    row.bri = 13'($urandom_range(8191));
                send_request(row);
            end
            drain_pixels();
        end

        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
